// ===== rtl/eemi_pkg.sv =====
package eemi_pkg;

    // operand width; coefficients carry one extra sign bit
    localparam int OPERAND_WIDTH = 32;
    localparam int COEF_WIDTH    = OPERAND_WIDTH + 1;
    localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

    typedef logic [OPERAND_WIDTH-1:0]     t_val;
    typedef logic [COEF_WIDTH-1:0]        t_coef_bits;
    typedef logic signed [COEF_WIDTH-1:0] t_coef;
    typedef logic [CNT_WIDTH-1:0]         t_cnt;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture a new word, seed the coefficients
        logic div_start;  // restart the divider on r0 / r1
        logic div_step;   // one restoring division bit
        logic update;     // shift the Euclid pair and restart the divider
        logic out_load;   // move the result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic op_zero;    // operand was zero
        logic div_last;   // last quotient bit this cycle
        logic rem_zero;   // remainder of the finished division is zero
        logic out_free;   // output register can take a word
    } t_status;

endpackage

// ===== rtl/eemi_if.sv =====
interface eemi_in_if;
    import eemi_pkg::*;

    logic valid;
    logic ready;
    t_val modulus;
    t_val operand;

    modport source (output valid, output modulus, output operand, input ready);
    modport sink   (input valid, input modulus, input operand, output ready);
endinterface

interface eemi_out_if;
    import eemi_pkg::*;

    logic  valid;
    logic  ready;
    t_val  gcd_value;
    t_coef coef_u;
    t_coef coef_v;
    t_val  inverse_value;
    logic  has_inverse;

    modport source (output valid, output gcd_value, output coef_u, output coef_v,
                    output inverse_value, output has_inverse, input ready);
    modport sink   (input valid, input gcd_value, input coef_u, input coef_v,
                    input inverse_value, input has_inverse, output ready);
endinterface

// ===== rtl/eemi_ctrl.sv =====
module eemi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  eemi_pkg::t_status i_status,
    output eemi_pkg::t_cmd    o_cmd
);
    import eemi_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_TEST   = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.op_zero) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_TEST;
                end
            end
            ST_TEST: begin
                // zero remainder: r1 is the gcd, stop here
                if (i_status.rem_zero) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.update = 1'b1;
                    n_state      = ST_DIV;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/eemi_dp.sv =====
module eemi_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  eemi_pkg::t_val    i_modulus,
    input  eemi_pkg::t_val    i_operand,
    input  eemi_pkg::t_cmd    i_cmd,
    output eemi_pkg::t_status o_status,
    eemi_out_if.source        o_word
);
    import eemi_pkg::*;

    localparam int W = OPERAND_WIDTH;

    // Euclid pair and coefficients (coefficients mod 2^(W+1))
    t_val       r_m;
    t_val       r_r0;
    t_val       r_r1;
    t_coef_bits r_u0;
    t_coef_bits r_u1;
    t_coef_bits r_v0;
    t_coef_bits r_v1;
    logic       r_op_zero;

    // divider state; q*u1 and q*v1 built MSB first alongside the quotient
    t_val       r_rem;
    t_val       r_dvd;
    t_coef_bits r_qu;
    t_coef_bits r_qv;
    t_cnt       r_cnt;

    // output register
    logic       r_out_valid;
    t_val       r_out_gcd;
    t_coef_bits r_out_u;
    t_coef_bits r_out_v;
    t_val       r_out_inv;
    logic       r_out_ok;

    logic [W:0] rem_sh;
    logic [W:0] rem_diff;
    logic       q_bit;
    t_val       res_gcd;
    t_coef_bits res_u;
    t_coef_bits res_v;
    t_val       res_inv;
    logic       res_ok;

    // one restoring division step
    assign rem_sh   = {r_rem, r_dvd[W-1]};
    assign rem_diff = rem_sh - {1'b0, r_r1};
    assign q_bit    = !rem_diff[W];

    // result selection and inverse fix-up
    always_comb begin
        if (r_op_zero) begin
            res_gcd = r_m;
            res_u   = t_coef_bits'(1);
            res_v   = '0;
        end else begin
            res_gcd = r_r1;
            res_u   = r_u1;
            res_v   = r_v1;
        end
        res_ok  = (res_gcd == t_val'(1));
        res_inv = '1;
        if (res_ok) begin
            res_inv = res_v[W] ? (res_v[W-1:0] + r_m) : res_v[W-1:0];
        end
    end

    // Euclid and divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m       <= i_modulus;
            r_r0      <= i_modulus;
            r_r1      <= i_operand;
            r_u0      <= t_coef_bits'(1);
            r_v0      <= '0;
            r_u1      <= '0;
            r_v1      <= t_coef_bits'(1);
            r_op_zero <= (i_operand == '0);
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_dvd <= r_r0;
            r_qu  <= '0;
            r_qv  <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= q_bit ? rem_diff[W-1:0] : rem_sh[W-1:0];
            r_dvd <= {r_dvd[W-2:0], 1'b0};
            r_qu  <= {r_qu[W-1:0], 1'b0} + (q_bit ? r_u1 : '0);
            r_qv  <= {r_qv[W-1:0], 1'b0} + (q_bit ? r_v1 : '0);
            r_cnt <= r_cnt + t_cnt'(1);
        end
        if (i_cmd.update) begin
            r_r0  <= r_r1;
            r_r1  <= r_rem;
            r_u0  <= r_u1;
            r_u1  <= r_u0 - r_qu;
            r_v0  <= r_v1;
            r_v1  <= r_v0 - r_qv;
            // next division on the new pair
            r_rem <= '0;
            r_dvd <= r_r1;
            r_qu  <= '0;
            r_qv  <= '0;
            r_cnt <= '0;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_word.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_gcd <= res_gcd;
            r_out_u   <= res_u;
            r_out_v   <= res_v;
            r_out_inv <= res_inv;
            r_out_ok  <= res_ok;
        end
    end

    assign o_status.op_zero  = r_op_zero;
    assign o_status.div_last = (r_cnt == t_cnt'(W - 1));
    assign o_status.rem_zero = (r_rem == '0);
    assign o_status.out_free = !r_out_valid || o_word.ready;

    assign o_word.valid         = r_out_valid;
    assign o_word.gcd_value     = r_out_gcd;
    assign o_word.coef_u        = t_coef'(r_out_u);
    assign o_word.coef_v        = t_coef'(r_out_v);
    assign o_word.inverse_value = r_out_inv;
    assign o_word.has_inverse   = r_out_ok;

endmodule

// ===== rtl/extended_euclid_modular_inverse.sv =====
// Channel   Dir  Word fields
// i_word    in   modulus, operand
// o_word    out  gcd_value, coef_u, coef_v, inverse_value, has_inverse
//
// One word at a time. Euclid runs k divisions per word (k = 0 for a zero operand, at
// most 46 at 32 bits); each division is a one-bit-per-cycle restoring divider.
// Reset is synchronous, active low, and clears the controller and output valid.
// A finished word waits in the output register while the next input is taken;
// the engine stalls only when it finishes with that register still full.
module extended_euclid_modular_inverse (
    input  logic       i_clk,
    input  logic       i_rst_n,
    eemi_in_if.sink    i_word,
    eemi_out_if.source o_word
);
    import eemi_pkg::*;

    t_cmd    cmd;
    t_status status;

    eemi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_word.valid),
        .o_in_ready (i_word.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    eemi_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_modulus (i_word.modulus),
        .i_operand (i_word.operand),
        .i_cmd     (cmd),
        .o_status  (status),
        .o_word    (o_word)
    );

`ifndef ASSERT_OFF
    // engine is busy right after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_word.valid && i_word.ready) |=> !i_word.ready)
        else $error("input ready right after accept");

    // inverse flag matches a unit gcd
    a_flag_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word.valid |-> (o_word.has_inverse == (o_word.gcd_value == t_val'(1))))
        else $error("has_inverse disagrees with gcd");

    // no inverse reads as all ones
    a_no_inv_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.valid && !o_word.has_inverse) |-> (o_word.inverse_value == '1))
        else $error("missing inverse not all ones");

    // a result is only loaded when the engine is not idle
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !i_word.ready)
        else $error("result loaded while idle");
`endif

endmodule
